[hdl/rpsu_pkg.sv]
`timescale 1ns / 1ps

package rpsu_pkg;

  // Width of the configuration write data, set by the widest register.
  localparam int CfgDataW = 14;
  localparam int CfgIdxW  = 3;

  // Depth of the job queue between the byte front end and the pixel back end.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PACKING_FORMAT = 3'd0,
    CFG_PIXEL_BITS     = 3'd1,
    CFG_HIGH_ALIGNED   = 3'd2,
    CFG_LOW_BYTE_FIRST = 3'd3,
    CFG_LINE_WIDTH     = 3'd4
  } cfg_idx_e;

  // Packing formats of the raw stream.
  typedef enum logic [1:0] {
    FMT_WORD16    = 2'd0,
    FMT_RAW10     = 2'd1,
    FMT_RAW10_PAD = 2'd2,
    FMT_RAW10_LE  = 2'd3
  } fmt_e;

  // Register values after reset.
  localparam fmt_e         RstPackingFormat = FMT_RAW10;
  localparam logic [4:0]   RstPixelBits     = 5'd10;
  localparam logic         RstHighAligned   = 1'b0;
  localparam logic         RstLowByteFirst  = 1'b1;
  localparam logic [13:0]  RstLineWidth     = 14'd4096;

  // One input transaction: a byte of the packed stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  // One output transaction: a right-aligned pixel.
  typedef struct packed {
    logic [15:0] pixel_value;
    logic        run_last;
    logic        range_error;
  } out_t;

  // One unit of work for the back end: one word pixel or four RAW10 pixels.
  typedef struct packed {
    logic             four;
    logic [3:0][15:0] pix;
    logic             err;
  } job_t;

endpackage

[hdl/rpsu_front.sv]
`timescale 1ns / 1ps

module rpsu_front import rpsu_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  in_t                 in_data_i,
  input  logic                queue_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output job_t                job_o
);

  localparam int LwW       = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CmpW      = (LwW > CfgDataW) ? LwW : CfgDataW;
  localparam int MaxStride = ((((MAX_LINE_WIDTH * 5) >> 2) + 8) / 8) * 8;
  localparam int PosW      = $clog2(MaxStride + 1);

  // Configuration registers.
  fmt_e                fmt_q;
  logic [4:0]          pixel_bits_q;
  logic                high_aligned_q;
  logic                low_byte_first_q;
  logic [CfgDataW-1:0] line_width_q;
  logic                cfg_hit;

  // Group state.
  logic [3:0][7:0]     gb_q;
  logic [2:0]          gi_q, gi_d, gi_eff;
  logic [PosW-1:0]     pos_q, pos_d, pos_eff;
  logic                gb_we;
  logic [1:0]          gb_waddr;

  logic                accept;
  logic [7:0]          b;

  // Line geometry of the padded format.
  logic [CmpW-1:0]     lw_ext, lw_clamp;
  logic [LwW-1:0]      w_eff, w_quarter;
  logic [LwW+2:0]      w_times5;
  logic [PosW-1:0]     data_bytes, stride_sum, stride;
  logic [PosW:0]       pos_inc;
  logic                pos_in_data, pos_wrap;

  // Word format datapath.
  logic [4:0]          nb;
  logic [16:0]         mask_full;
  logic [15:0]         mask, word, word_sh;
  logic [4:0]          shamt;
  logic                word_err;

  // RAW10 datapath.
  logic                raw_step, raw_emit;
  logic [3:0][15:0]    raw_pix_be, raw_pix_le;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;

  // Configuration writes; a write to a known register also restarts the group.
  always_comb begin
    unique case (cfg_index_i)
      CFG_PACKING_FORMAT, CFG_PIXEL_BITS, CFG_HIGH_ALIGNED,
      CFG_LOW_BYTE_FIRST, CFG_LINE_WIDTH: cfg_hit = 1'b1;
      default:                            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q            <= RstPackingFormat;
      pixel_bits_q     <= RstPixelBits;
      high_aligned_q   <= RstHighAligned;
      low_byte_first_q <= RstLowByteFirst;
      line_width_q     <= RstLineWidth;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PACKING_FORMAT: fmt_q            <= fmt_e'(cfg_data_i[1:0]);
        CFG_PIXEL_BITS:     pixel_bits_q     <= cfg_data_i[4:0];
        CFG_HIGH_ALIGNED:   high_aligned_q   <= cfg_data_i[0];
        CFG_LOW_BYTE_FIRST: low_byte_first_q <= cfg_data_i[0];
        CFG_LINE_WIDTH:     line_width_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stride and data length of a padded line, from the clamped width.
  always_comb begin
    lw_ext     = CmpW'(line_width_q);
    lw_clamp   = (lw_ext > CmpW'(MAX_LINE_WIDTH)) ? CmpW'(MAX_LINE_WIDTH) : lw_ext;
    w_eff      = lw_clamp[LwW-1:0];
    w_quarter  = w_eff >> 2;
    w_times5   = {w_eff, 2'b00} + (LwW+3)'(w_eff);
    data_bytes = PosW'({w_quarter, 2'b00}) + PosW'(w_quarter);
    stride_sum = PosW'(w_times5 >> 2) + PosW'(8);
    stride     = {stride_sum[PosW-1:3], 3'b000};
  end

  // A frame start clears the counters before its byte is taken.
  assign gi_eff  = in_data_i.frame_start ? 3'd0 : gi_q;
  assign pos_eff = in_data_i.frame_start ? '0 : pos_q;

  assign pos_inc     = {1'b0, pos_eff} + (PosW+1)'(1);
  assign pos_in_data = pos_eff < data_bytes;
  assign pos_wrap    = pos_inc >= {1'b0, stride};

  // Word pixel: byte order, optional shift from the top, mask and overflow flag.
  always_comb begin
    if (pixel_bits_q == 5'd0) begin
      nb = 5'd1;
    end else if (pixel_bits_q > 5'd16) begin
      nb = 5'd16;
    end else begin
      nb = pixel_bits_q;
    end
    mask_full = (17'd1 << nb) - 17'd1;
    mask      = mask_full[15:0];
    shamt     = 5'd16 - nb;
    word      = low_byte_first_q ? {b, gb_q[0]} : {gb_q[0], b};
    word_sh   = high_aligned_q ? (word >> shamt[3:0]) : word;
    word_err  = |(word_sh & ~mask);
  end

  // Four RAW10 pixels from the held group and the closing byte.
  always_comb begin
    raw_pix_be[0] = 16'({gb_q[0], b[7:6]});
    raw_pix_be[1] = 16'({gb_q[1], b[5:4]});
    raw_pix_be[2] = 16'({gb_q[2], b[3:2]});
    raw_pix_be[3] = 16'({gb_q[3], b[1:0]});
    raw_pix_le[0] = 16'({gb_q[1][1:0], gb_q[0]});
    raw_pix_le[1] = 16'({gb_q[2][3:0], gb_q[1][7:2]});
    raw_pix_le[2] = 16'({gb_q[3][5:0], gb_q[2][7:4]});
    raw_pix_le[3] = 16'({b, gb_q[3][7:6]});
  end

  // Byte classification: store into the group, emit a job, or drop padding.
  always_comb begin
    gi_d     = gi_q;
    pos_d    = pos_q;
    gb_we    = 1'b0;
    gb_waddr = gi_eff[1:0];
    raw_step = 1'b0;
    push_o   = 1'b0;
    job_o    = '0;
    if (accept) begin
      gi_d = gi_eff;
      unique case (fmt_q)
        FMT_WORD16: begin
          if (gi_eff == 3'd0) begin
            gb_we    = 1'b1;
            gb_waddr = 2'd0;
            gi_d     = 3'd1;
          end else begin
            gi_d       = 3'd0;
            push_o     = 1'b1;
            job_o.four = 1'b0;
            job_o.pix[0] = word_sh & mask;
            job_o.err  = word_err;
          end
        end
        FMT_RAW10_PAD: begin
          raw_step = pos_in_data;
        end
        FMT_RAW10, FMT_RAW10_LE: begin
          raw_step = 1'b1;
        end
        default: ;
      endcase
      if (raw_step) begin
        if (!gi_eff[2]) begin
          gb_we = 1'b1;
          gi_d  = gi_eff + 3'd1;
        end else begin
          gi_d       = 3'd0;
          push_o     = 1'b1;
          job_o.four = 1'b1;
          job_o.pix  = (fmt_q == FMT_RAW10_LE) ? raw_pix_le : raw_pix_be;
          job_o.err  = 1'b0;
        end
      end
      // Only the padded format tracks the position within a line.
      if (fmt_q == FMT_RAW10_PAD) begin
        if (pos_wrap) begin
          pos_d = '0;
          gi_d  = 3'd0;
        end else begin
          pos_d = pos_inc[PosW-1:0];
        end
      end
    end
  end

  assign raw_emit = raw_step && gi_eff[2];

  // Counters; a configuration write to a known register restarts them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gi_q  <= 3'd0;
      pos_q <= '0;
    end else if (cfg_we_i && cfg_hit) begin
      gi_q  <= 3'd0;
      pos_q <= '0;
    end else begin
      gi_q  <= gi_d;
      pos_q <= pos_d;
    end
  end

  // Group bytes hold payload only.
  always_ff @(posedge clk_i) begin
    if (gb_we && !raw_emit) begin
      gb_q[gb_waddr] <= b;
    end
  end

endmodule

[hdl/rpsu_queue.sv]
`timescale 1ns / 1ps

module rpsu_queue import rpsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = count_q == QueueCntW'(QueueDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      count_q <= count_q + QueueCntW'(do_push) - QueueCntW'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[hdl/rpsu_back.sv]
`timescale 1ns / 1ps

module rpsu_back import rpsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic queue_empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  job_t       cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       fire, last;

  assign fire  = busy_q && out_ready_i;
  assign last  = idx_q == (cur_q.four ? 2'd3 : 2'd0);
  assign pop_o = !queue_empty_i && (!busy_q || (fire && last));

  // Step through the pixels of the current job, loading the next without a gap.
  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (pop_o) begin
      cur_d  = job_i;
      idx_d  = 2'd0;
      busy_d = 1'b1;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // The held job drives the output transaction.
  assign out_valid_o             = busy_q;
  assign out_data_o.pixel_value  = cur_q.pix[idx_q];
  assign out_data_o.run_last     = last;
  assign out_data_o.range_error  = cur_q.err;

endmodule

[hdl/raw_pixel_stream_unpacker.sv]
`timescale 1ns / 1ps

// Raw pixel stream unpacker: takes one byte of a packed camera stream per
// cycle and returns right-aligned pixels, one per cycle. The front end
// classifies each byte in the cycle it is accepted, so a byte can enter on
// every clock as long as the two-entry job queue has room; a completed result
// is written into the job queue and then loaded into the back end's job
// register before its first pixel is presented.
// The back end delivers one pixel per cycle while the output is ready, four
// for a RAW10 group of five bytes and one for a 16-bit word, and input only
// stalls when the output side is held off. Configuration must be written
// while no bytes or pixels are in flight.
module raw_pixel_stream_unpacker import rpsu_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  // Byte classification and group assembly.
  rpsu_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (q_full),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .job_o        (job_in)
  );

  // Decoupling queue.
  rpsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  // Pixel serialization.
  rpsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .job_i         (job_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

[hdl/rpsu_checker.sv]
`timescale 1ns / 1ps

module rpsu_checker import rpsu_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_t                 in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_t                out_data_o
);

  // A stalled input transaction holds its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

  // A stalled output transaction holds its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled output transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // An overflow flag only comes with a single word pixel, which ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_error |-> out_data_o.run_last)
    else $error("range error on a pixel that does not end its run");

  // The pixels of one run follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.run_last |=> out_valid_o)
    else $error("gap inside a run of pixels");

endmodule

bind raw_pixel_stream_unpacker rpsu_checker u_rpsu_checker (.*);
